@@ rtl/core/blake2b_hash_defines.svh @@
`ifndef BLAKE2B_HASH_DEFINES_SVH
`define BLAKE2B_HASH_DEFINES_SVH
// Implication checks used by the hash core.
`define B2B_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define B2B_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

@@ rtl/core/b2b_pkg.sv @@
package b2b_pkg;
  typedef logic [63:0] word_t;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUND_COUNT = 12;
  localparam logic [31:0] PARAM_CONST = 32'h0101_0000;

  function automatic word_t iv(input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  // Message schedule: word index for round r, slot j.
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] j);
    logic [63:0] row;
    unique case (r)
      4'd0: row = 64'hFEDCBA9876543210;
      4'd1: row = 64'h357B20C16DF984AE;
      4'd2: row = 64'h491763EADF250C8B;
      4'd3: row = 64'h8F04A562EBCD1397;
      4'd4: row = 64'hD386CB1EFA427509;
      4'd5: row = 64'h91EF57D438B0A6C2;
      4'd6: row = 64'hB8293670A4DEF15C;
      4'd7: row = 64'hA2684F05931CE7BD;
      4'd8: row = 64'h5A417D2C803B9EF6;
      default: row = 64'h0DC3E9BF5167482A;
    endcase
    return row[j*4 +: 4];
  endfunction

  // Mix lanes a,b,c,d for step g, packed nibbles d,c,b,a.
  function automatic logic [15:0] mixidx(input logic [2:0] g);
    logic [15:0] r;
    unique case (g)
      3'd0: r = 16'hC840;
      3'd1: r = 16'hD951;
      3'd2: r = 16'hEA62;
      3'd3: r = 16'hFB73;
      3'd4: r = 16'hFA50;
      3'd5: r = 16'hCB61;
      3'd6: r = 16'hD872;
      default: r = 16'hE943;
    endcase
    return r;
  endfunction
endpackage

@@ rtl/core/b2b_stream_if.sv @@
interface b2b_in_if;
  logic valid;
  logic ready;
  logic [63:0] data_word;
  logic [3:0] valid_bytes;
  logic last_word;
  modport source (output valid, data_word, valid_bytes, last_word, input ready);
  modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface b2b_out_if;
  logic valid;
  logic ready;
  logic [63:0] digest_word;
  logic digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface

@@ rtl/core/blake2b_hash.sv @@
// Channel   Dir  Payload
// in        in   data_word[63:0], valid_bytes[3:0], last_word
// out       out  digest_word[63:0], digest_last
// apb       in   digest_bytes at address 0
// A word is taken while idle; a word that adds bytes to a held full block
// waits (ready low) while that block is compressed, and a last word runs the
// final compression.
// One compression is 12 rounds x 8 mix steps, half a mix step per cycle on one
// shared unit; the result is then folded into the chain value word by word.
// Digest words then leave one per cycle as the sink takes them; no input meanwhile.
// Reset (rst, synchronous) loads the IV in the following cycle; a length write restarts the message.
`include "blake2b_hash_defines.svh"
module blake2b_hash (
  input  logic clk,
  input  logic rst,
  b2b_in_if.sink in,
  b2b_out_if.source out,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import b2b_pkg::*;

  typedef enum logic [2:0] {IDLE, INIT, MIX, FOLD, EMIT} state_t;

  state_t state;
  word_t chain [8];
  word_t msg [BLOCK_WORDS];
  word_t v [16];
  logic [4:0] words_held;
  word_t byte_counter;
  logic [6:0] digest_bytes;
  logic [3:0] round;
  logic [2:0] step;
  logic half;
  logic final_blk;
  logic [2:0] ocnt;

  logic [6:0] eff_len;
  logic [3:0] vb;
  word_t wmask;
  logic [3:0] ia, ib, ic, id;
  word_t m0, va1, vd1, vc1, vb1;
  logic wr;
  logic [2:0] nwords;
  logic [6:0] rem;
  word_t out_w;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = {25'd0, digest_bytes};
  assign eff_len = (digest_bytes == 7'd0) ? 7'd1 :
                   (digest_bytes > 7'd64) ? 7'd64 : digest_bytes;
  assign nwords = 3'((eff_len - 7'd1) >> 3);

  always_comb begin
    vb = in.last_word ? ((in.valid_bytes > 4'd8) ? 4'd8 : in.valid_bytes) : 4'd8;
    wmask = (vb == 4'd8) ? '1 : ((64'd1 << {vb[2:0], 3'd0}) - 64'd1);
  end

  // One half of G per cycle.
  always_comb begin
    logic [15:0] mi;
    logic [3:0] rr;
    word_t xd, xb;
    mi = mixidx(step);
    ia = mi[3:0]; ib = mi[7:4]; ic = mi[11:8]; id = mi[15:12];
    rr = (round >= 4'd10) ? round - 4'd10 : round;
    m0 = msg[sigma(rr, {step, half})];
    va1 = v[ia] + v[ib] + m0;
    xd = v[id] ^ va1;
    vd1 = half ? {xd[15:0], xd[63:16]} : {xd[31:0], xd[63:32]};
    vc1 = v[ic] + vd1;
    xb = v[ib] ^ vc1;
    vb1 = half ? {xb[62:0], xb[63]} : {xb[23:0], xb[63:24]};
  end

  assign rem = eff_len - {1'b0, ocnt, 3'd0};
  assign out_w = (rem >= 7'd8) ? chain[ocnt]
               : chain[ocnt] & ((64'd1 << {rem[2:0], 3'd0}) - 64'd1);
  // hold off a word that adds bytes while a full block waits for compression
  assign in.ready = (state == IDLE) && !wr && !(words_held == 5'd16 && vb != 4'd0);
  assign out.valid = (state == EMIT);
  assign out.digest_word = out_w;
  assign out.digest_last = (ocnt == nwords);

  always_ff @(posedge clk) begin
    if (rst || wr) begin
      if (rst) digest_bytes <= 7'd64;
      else digest_bytes <= pwdata[6:0];
      state <= INIT;
      words_held <= '0;
      byte_counter <= '0;
      for (int i = 0; i < BLOCK_WORDS; i++) msg[i] <= '0;
    end else begin
      unique case (state)
        INIT: begin
          for (int i = 1; i < 8; i++) chain[i] <= iv(3'(i));
          chain[0] <= iv(3'd0) ^ {32'd0, PARAM_CONST | {25'd0, eff_len}};
          state <= IDLE;
        end
        IDLE: begin
          if (in.valid) begin
            if (vb != 4'd0 && words_held == 5'd16) begin
              // hold the word until the full block is compressed
              final_blk <= 1'b0;
              state <= MIX;
            end else begin
              if (vb != 4'd0) begin
                msg[words_held[3:0]] <= in.data_word & wmask;
                words_held <= words_held + 5'd1;
                byte_counter <= byte_counter + {60'd0, vb};
              end
              if (in.last_word) begin
                final_blk <= 1'b1;
                state <= MIX;
              end
            end
            if (state == IDLE && (in.last_word || (vb != 4'd0 && words_held == 5'd16))) begin
              for (int i = 0; i < 8; i++) begin
                v[i] <= chain[i];
                if (i != 4 && i != 6) v[i+8] <= iv(3'(i));
              end
              v[12] <= iv(3'd4) ^ ((vb != 4'd0 && words_held != 5'd16)
                       ? byte_counter + {60'd0, vb} : byte_counter);
              v[14] <= (vb != 4'd0 && words_held == 5'd16) ? iv(3'd6) : ~iv(3'd6);
              round <= '0; step <= '0; half <= 1'b0; ocnt <= '0;
            end
          end
        end
        MIX: begin
          v[ia] <= va1; v[id] <= vd1; v[ic] <= vc1; v[ib] <= vb1;
          half <= !half;
          if (half) begin
            step <= step + 3'd1;
            if (step == 3'd7) begin
              if (round == 4'(ROUND_COUNT - 1)) state <= FOLD;
              else round <= round + 4'd1;
            end
          end
        end
        FOLD: begin
          chain[ocnt] <= chain[ocnt] ^ v[ocnt] ^ v[{1'b1, ocnt}];
          // ocnt wraps to zero after the last chain word
          ocnt <= ocnt + 3'd1;
          if (ocnt == 3'd7) begin
            if (final_blk) state <= EMIT;
            else begin
              state <= IDLE;
              words_held <= '0;
              for (int i = 0; i < BLOCK_WORDS; i++) msg[i] <= '0;
            end
          end
        end
        EMIT: begin
          if (out.ready) begin
            ocnt <= ocnt + 3'd1;
            if (ocnt == nwords) begin
              state <= INIT;
              words_held <= '0;
              byte_counter <= '0;
              for (int i = 0; i < BLOCK_WORDS; i++) msg[i] <= '0;
            end
          end
        end
        default: state <= INIT;
      endcase
    end
  end

  `B2B_ASSERT_IMP(a_no_in_busy, state != IDLE, !in.ready)
  `B2B_ASSERT_IMP(a_held_range, 1'b1, words_held <= 5'd16)
  `B2B_ASSERT_IMP(a_out_range, out.valid, ocnt <= nwords)
  `B2B_ASSERT_NEXT(a_last_ends, out.valid && out.ready && out.digest_last, state == INIT)
endmodule
